// File: design/rbb_pkg.sv
// Shared types, constants and pointer-update functions for the rx byte buffer.
package rbb_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = 6;

    localparam logic       MODE_RING   = 1'b0;
    localparam logic       MODE_LINEAR = 1'b1;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_LINE  = 2'd2,
        FUNC_FLUSH = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             valid_res;
        logic             last;
        logic [PTR_W-1:0] fill_count;
    } res_t;

    // one result transaction leaving the controller
    typedef struct packed {
        logic strobe;
        res_t res;
    } res_evt_t;

    typedef struct packed {
        logic [ADDR_W-1:0] slot;
        logic [PTR_W-1:0]  rp;
        logic [PTR_W-1:0]  wp;
    } pop_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] slot;
        logic [PTR_W-1:0]  wp;
    } push_t;

    // pointer at or past the end is treated as slot 0
    function automatic logic [ADDR_W-1:0] slot_of(logic [PTR_W-1:0] p);
        slot_of = (p < PTR_W'(DEPTH)) ? p[ADDR_W-1:0] : '0;
    endfunction

    function automatic pop_t pop_step(logic [PTR_W-1:0] rp, logic [PTR_W-1:0] wp,
                                      logic mode);
        pop_t             r;
        logic [PTR_W-1:0] n;
        r.slot = slot_of(rp);
        n      = PTR_W'(r.slot) + PTR_W'(1);
        r.rp   = n;
        r.wp   = wp;
        if (mode == MODE_LINEAR && n == wp)
        begin
            r.rp = '0;
            r.wp = '0;
        end
        else if (n >= PTR_W'(DEPTH))
        begin
            r.rp = '0;
        end
        return r;
    endfunction

    function automatic push_t push_step(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] cnt,
                                        logic mode);
        push_t            r;
        logic [PTR_W-1:0] n;
        r.ok   = (cnt < PTR_W'(DEPTH)) &&
                 !(mode == MODE_LINEAR && wp >= PTR_W'(DEPTH));
        r.slot = slot_of(wp);
        n      = PTR_W'(r.slot) + PTR_W'(1);
        if (mode == MODE_RING && n >= PTR_W'(DEPTH))
        begin
            n = '0;
        end
        r.wp = n;
        return r;
    endfunction

endpackage

// File: design/rbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rbb_ctrl.sv
// Sequencer: pointers, fill count, RAM access and result generation.
module rbb_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rbb_pkg::cmd_t           cmd,
    input  logic                    mode,
    output logic                    busy,
    output rbb_pkg::res_evt_t       evt,
    output logic                    mem_we,
    output logic [rbb_pkg::ADDR_W-1:0] mem_waddr,
    output logic [7:0]              mem_wdata,
    output logic [rbb_pkg::ADDR_W-1:0] mem_raddr,
    input  logic [7:0]              mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [rbb_pkg::PTR_W-1:0]   wp_reg, wp_next;
    logic [rbb_pkg::PTR_W-1:0]   rp_reg, rp_next;
    logic [rbb_pkg::PTR_W-1:0]   cnt_reg, cnt_next;
    logic                        line_reg, line_next;
    logic [rbb_pkg::ADDR_W-1:0]  clr_reg, clr_next;
    rbb_pkg::pop_t               pop;
    rbb_pkg::push_t              push;
    logic                        line_end;

    assign pop      = rbb_pkg::pop_step(rp_reg, wp_reg, mode);
    assign push     = rbb_pkg::push_step(wp_reg, cnt_reg, mode);
    assign line_end = (mem_rdata == rbb_pkg::CHAR_NL) || (mem_rdata == rbb_pkg::CHAR_NUL);
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        mem_raddr  = pop.slot;
        evt        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        rbb_pkg::FUNC_PUT:
                        begin
                            evt.strobe        = 1'b1;
                            evt.res.valid_res = push.ok;
                            evt.res.last      = 1'b1;
                            evt.res.fill_count = cnt_reg;
                            if (push.ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = push.slot;
                                mem_wdata = cmd.data_in;
                                wp_next   = push.wp;
                                cnt_next  = cnt_reg + rbb_pkg::PTR_W'(1);
                                evt.res.fill_count = cnt_next;
                            end
                        end
                        rbb_pkg::FUNC_GET, rbb_pkg::FUNC_LINE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                evt.strobe   = 1'b1;
                                evt.res.last = 1'b1;
                            end
                            else
                            begin
                                rp_next    = pop.rp;
                                wp_next    = pop.wp;
                                cnt_next   = cnt_reg - rbb_pkg::PTR_W'(1);
                                line_next  = (cmd.func == rbb_pkg::FUNC_LINE);
                                state_next = ST_READ;
                            end
                        end
                        rbb_pkg::FUNC_FLUSH:
                        begin
                            wp_next      = '0;
                            rp_next      = '0;
                            cnt_next     = '0;
                            clr_next     = '0;
                            state_next   = ST_CLEAR;
                            evt.strobe   = 1'b1;
                            evt.res.last = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // data for the pop issued last cycle is on the RAM output
                evt.strobe         = 1'b1;
                evt.res.data_out   = mem_rdata;
                evt.res.valid_res  = 1'b1;
                evt.res.fill_count = cnt_reg;
                if (!line_reg || line_end)
                begin
                    evt.res.last = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    rp_next  = pop.rp;
                    wp_next  = pop.wp;
                    cnt_next = cnt_reg - rbb_pkg::PTR_W'(1);
                end
            end
            ST_TAIL:
            begin
                evt.strobe         = 1'b1;
                evt.res.last       = 1'b1;
                evt.res.fill_count = cnt_reg;
                state_next         = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg == rbb_pkg::ADDR_W'(rbb_pkg::DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + rbb_pkg::ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            line_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            clr_reg   <= clr_next;
        end
    end

    // fill count never exceeds capacity
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rbb_pkg::PTR_W'(rbb_pkg::DEPTH))
        else $error("fill count above capacity");

    // RAM is never written while a read is in flight
    a_no_wr_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_CLEAR))
        else $error("RAM write during read");

    // flush empties the buffer and starts the clear sweep
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == rbb_pkg::FUNC_FLUSH)
        |=> (cnt_reg == '0 && state_reg == ST_CLEAR))
        else $error("flush did not empty buffer");

    // trailing empty result only after the buffer ran dry
    a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL) |-> (cnt_reg == '0 && $past(state_reg) == ST_READ))
        else $error("tail result with data left");

endmodule

// File: design/rx_byte_buffer_ring_linear_core.sv
// Top level of the rx byte buffer: mode register, result register, RAM and sequencer.
// Results of put, flush and get on empty pass through the result register only;
//   a popped byte passes the RAM's registered read port, then the result register.
// busy is high, and no transaction is taken, while a get or get-line reads bytes
//   (closing with an empty result if the buffer runs dry) or a flush clears the RAM.
// Reset clears pointers, fill count and control; mode resets to linear; RAM content
//   is undefined until written. Results cannot be stalled by the receiver.
module rx_byte_buffer_ring_linear_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rbb_pkg::cmd_t cmd,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    output logic          res_strobe,
    output rbb_pkg::res_t res
);

    // buffer mode: ring or linear pointers
    logic mode_reg;

    // registered result port; one transaction per strobe cycle
    logic          res_strobe_reg;
    rbb_pkg::res_t res_reg;

    rbb_pkg::res_evt_t           evt;
    logic                        mem_we;
    logic [rbb_pkg::ADDR_W-1:0]  mem_waddr;
    logic [7:0]                  mem_wdata;
    logic [rbb_pkg::ADDR_W-1:0]  mem_raddr;
    logic [7:0]                  mem_rdata;

    // byte store: written by put and the flush sweep; read data is registered, so it is read ahead of use
    rbb_ram #(
        .WIDTH (8),
        .DEPTH (rbb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer; it only touches the RAM from one state at a time, so a write
    // and a dependent read never land in the same cycle (no forwarding needed)
    rbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .mode      (mode_reg),
        .busy      (busy),
        .evt       (evt),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // mode register: the user must write it only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rbb_pkg::MODE_LINEAR;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // output stage: strobe is control, payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= evt.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.strobe)
        begin
            res_reg <= evt.res;
        end
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

endmodule

// File: dv/rx_byte_buffer_ring_linear_core_tb.sv
// Self-checking testbench for the rx byte buffer core: directed table, then random phases.
`timescale 1ns / 1ps

module rx_byte_buffer_ring_linear_core_tb;

    import rbb_pkg::*;

    // Longest correct span with no accepted transaction is a flush sweep plus an
    // idle gap or a config pause; this is many times that.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 36;
    localparam int N_DIR        = 21;

    typedef struct {
        func_t      func;
        logic [7:0] data;
        bit         typed;
        res_t       want;
    } dir_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  cfg_we;
    logic  cfg_wdata;
    logic  res_strobe;
    res_t  res;

    // Shadow of the buffer, kept in step with every accepted transaction
    logic [7:0]       shadow_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] held;
    logic             mode_q;

    res_t     op_results[$];    // results of the transaction just accepted
    res_t     due_results[$];   // results still to come out of the core, oldest first
    dir_row_t dir_rows [N_DIR];

    int fails;
    int ops_sent;
    int stall_cycles;
    bit no_idle;

    rx_byte_buffer_ring_linear_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .res_strobe (res_strobe),
        .res        (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow buffer
    // ------------------------------------------------------------------

    // Pop the oldest byte. A pointer at or past the end reads slot 0; in linear
    // mode the pointers snap back to zero when the read pointer meets the write
    // pointer, otherwise the read pointer wraps at the end.
    task automatic pop_byte(output bit ok, output logic [7:0] b);
        logic [PTR_W-1:0] s;
        logic [PTR_W-1:0] nxt;
        ok = 1'b0;
        b  = 8'h00;
        if (held != '0)
        begin
            s    = (rd_ptr < PTR_W'(DEPTH)) ? rd_ptr : '0;
            b    = shadow_mem[s[ADDR_W-1:0]];
            held = held - PTR_W'(1);
            nxt  = s + PTR_W'(1);
            if (mode_q == MODE_LINEAR && nxt == wr_ptr)
            begin
                rd_ptr = '0;
                wr_ptr = '0;
            end
            else if (nxt >= PTR_W'(DEPTH))
            begin
                rd_ptr = '0;
            end
            else
            begin
                rd_ptr = nxt;
            end
            ok = 1'b1;
        end
    endtask

    // Store one byte; refused when full, or in linear mode once the write
    // pointer has run to the end.
    task automatic push_byte(input logic [7:0] b, output bit ok);
        logic [PTR_W-1:0] s;
        logic [PTR_W-1:0] nxt;
        ok = 1'b0;
        if (held < PTR_W'(DEPTH) &&
            !(mode_q == MODE_LINEAR && wr_ptr >= PTR_W'(DEPTH)))
        begin
            s   = (wr_ptr < PTR_W'(DEPTH)) ? wr_ptr : '0;
            shadow_mem[s[ADDR_W-1:0]] = b;
            nxt = s + PTR_W'(1);
            if (mode_q == MODE_RING && nxt >= PTR_W'(DEPTH))
                nxt = '0;
            wr_ptr = nxt;
            held   = held + PTR_W'(1);
            ok     = 1'b1;
        end
    endtask

    task automatic add_result(input logic [7:0] d, input logic v, input logic l);
        res_t r;
        r.data_out   = d;
        r.valid_res  = v;
        r.last       = l;
        r.fill_count = held;
        op_results.push_back(r);
    endtask

    // Apply one transaction to the shadow buffer and list the results it causes
    task automatic buffer_op(input cmd_t c);
        bit         ok;
        bit         done;
        logic [7:0] b;
        op_results.delete();
        case (c.func)
            FUNC_PUT:
            begin
                push_byte(c.data_in, ok);
                add_result(8'h00, ok, 1'b1);
            end
            FUNC_GET:
            begin
                pop_byte(ok, b);
                add_result(b, ok, 1'b1);
            end
            FUNC_LINE:
            begin
                // one result per byte until a newline or NUL; running dry adds
                // a closing empty result
                done = 1'b0;
                while (!done)
                begin
                    pop_byte(ok, b);
                    if (!ok)
                    begin
                        add_result(8'h00, 1'b0, 1'b1);
                        done = 1'b1;
                    end
                    else if (b == CHAR_NL || b == CHAR_NUL)
                    begin
                        add_result(b, 1'b1, 1'b1);
                        done = 1'b1;
                    end
                    else
                    begin
                        add_result(b, 1'b1, 1'b0);
                    end
                end
            end
            default:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                held   = '0;
                for (int i = 0; i < DEPTH; i++)
                    shadow_mem[i] = 8'h00;
                add_result(8'h00, 1'b0, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one transaction at a falling edge, optionally after idle cycles,
    // and hold it until the core takes it. start stays high into the next
    // transaction unless an idle gap lowers it.
    task automatic send_op(input cmd_t c, input bit typed, input res_t typed_res);
        bit idled;
        idled = 1'b0;
        @(negedge clk);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                if (!idled)
                begin
                    start <= 1'b0;
                    idled = 1'b1;
                end
                @(negedge clk);
            end
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        ops_sent++;
        buffer_op(c);
        if (typed)
        begin
            due_results.push_back(typed_res);
        end
        else
        begin
            foreach (op_results[i])
                due_results.push_back(op_results[i]);
        end
    endtask

    task automatic send_rand(input func_t f, input logic [7:0] d);
        cmd_t c;
        c.func    = f;
        c.data_in = d;
        send_op(c, 1'b0, '0);
    endtask

    // Mode changes only with the core idle: all results in, busy low (a flush
    // sweep may still run after its result), then a short settle.
    task automatic set_mode(input logic m);
        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_q = m;
    endtask

    function automatic dir_row_t mk_row(func_t f, logic [7:0] d, int typed,
                                        logic [7:0] dout, int v, int l,
                                        int fc);
        dir_row_t row;
        row.func            = f;
        row.data            = d;
        row.typed           = (typed != 0);
        row.want.data_out   = dout;
        row.want.valid_res  = 1'(v);
        row.want.last       = 1'(l);
        row.want.fill_count = PTR_W'(fc);
        return row;
    endfunction

    // One random phase: opens with a put burst near capacity that can fill the buffer
    // and run into refused puts, then lines most often (bytes, usually a terminator,
    // then get-line), with bursts, drains and random transactions mixed in.
    task automatic run_phase(input int n_items);
        int         phase_end;
        int         r;
        int         n;
        logic [7:0] b;
        phase_end = ops_sent + n_items;
        n = $urandom_range(30, 34);
        repeat (n) send_rand(FUNC_PUT, 8'($urandom));
        while (ops_sent < phase_end)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                n = $urandom_range(0, 5);
                repeat (n) send_rand(FUNC_PUT, 8'($urandom));
                if ($urandom_range(0, 4) != 0)
                begin
                    b = ($urandom_range(0, 1) != 0) ? CHAR_NL : CHAR_NUL;
                    send_rand(FUNC_PUT, b);
                end
                send_rand(FUNC_LINE, 8'($urandom));
            end
            else if (r < 60)
            begin
                n = $urandom_range(4, 12);
                repeat (n) send_rand(FUNC_PUT, 8'($urandom));
            end
            else if (r < 70)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_rand(FUNC_GET, 8'($urandom));
            end
            else
            begin
                send_rand(func_t'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: every strobe must match the oldest pending result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_strobe)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result transaction: data_out %0h", res.data_out);
                fails++;
            end
            else
            begin
                want = due_results.pop_front();
                if (res.data_out !== want.data_out)
                begin
                    $error("data_out: expected %0h, actual %0h", want.data_out,
                           res.data_out);
                    fails++;
                end
                if (res.valid_res !== want.valid_res)
                begin
                    $error("valid_res: expected %0b, actual %0b", want.valid_res,
                           res.valid_res);
                    fails++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, res.last);
                    fails++;
                end
                if (res.fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, actual %0d", want.fill_count,
                           res.fill_count);
                    fails++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no transaction accepted on either side
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || res_strobe))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_t c;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        fails     = 0;
        ops_sent  = 0;
        no_idle   = 1'b0;
        wr_ptr    = '0;
        rd_ptr    = '0;
        held      = '0;
        mode_q    = MODE_LINEAR;
        for (int i = 0; i < DEPTH; i++)
            shadow_mem[i] = 8'h00;

        // Directed table, linear mode out of reset. Typed rows are the ones
        // obvious by inspection; the rest go through the shadow buffer.
        dir_rows[0]  = mk_row(FUNC_GET,   8'h00, 1, 8'h00, 0, 1, 0);  // get on empty
        dir_rows[1]  = mk_row(FUNC_LINE,  8'h00, 1, 8'h00, 0, 1, 0);  // line on empty
        dir_rows[2]  = mk_row(FUNC_PUT,   8'h00, 1, 8'h00, 1, 1, 1);
        dir_rows[3]  = mk_row(FUNC_PUT,   8'hFF, 1, 8'h00, 1, 1, 2);
        dir_rows[4]  = mk_row(FUNC_PUT,   CHAR_NL, 1, 8'h00, 1, 1, 3);
        dir_rows[5]  = mk_row(FUNC_PUT,   8'h80, 0, '0, 0, 0, 0);
        dir_rows[6]  = mk_row(FUNC_PUT,   8'h7F, 0, '0, 0, 0, 0);
        dir_rows[7]  = mk_row(FUNC_GET,   8'hFF, 0, '0, 0, 0, 0);     // pops the NUL
        dir_rows[8]  = mk_row(FUNC_LINE,  8'h00, 0, '0, 0, 0, 0);     // ends on newline
        dir_rows[9]  = mk_row(FUNC_LINE,  8'h00, 0, '0, 0, 0, 0);     // runs dry
        dir_rows[10] = mk_row(FUNC_PUT,   8'h55, 0, '0, 0, 0, 0);
        dir_rows[11] = mk_row(FUNC_PUT,   8'hAA, 0, '0, 0, 0, 0);
        dir_rows[12] = mk_row(FUNC_PUT,   CHAR_NUL, 0, '0, 0, 0, 0);
        dir_rows[13] = mk_row(FUNC_LINE,  8'h00, 0, '0, 0, 0, 0);     // ends on NUL
        dir_rows[14] = mk_row(FUNC_PUT,   8'h01, 0, '0, 0, 0, 0);
        dir_rows[15] = mk_row(FUNC_PUT,   8'h02, 0, '0, 0, 0, 0);
        dir_rows[16] = mk_row(FUNC_FLUSH, 8'hFF, 1, 8'h00, 0, 1, 0);
        dir_rows[17] = mk_row(FUNC_GET,   8'h00, 1, 8'h00, 0, 1, 0);  // empty after flush
        dir_rows[18] = mk_row(FUNC_PUT,   8'hFE, 0, '0, 0, 0, 0);
        dir_rows[19] = mk_row(FUNC_GET,   8'h00, 0, '0, 0, 0, 0);
        dir_rows[20] = mk_row(FUNC_FLUSH, 8'h00, 1, 8'h00, 0, 1, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            c.func    = dir_rows[i].func;
            c.data_in = dir_rows[i].data;
            send_op(c, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases; the mode flips without a flush so pointers left at
        // the end in one mode are picked up by the other. The linear phase
        // runs with no idle cycles at all.
        set_mode(MODE_RING);
        run_phase(PHASE_ITEMS);
        set_mode(MODE_LINEAR);
        no_idle = 1'b1;
        run_phase(PHASE_ITEMS);
        no_idle = 1'b0;
        set_mode(MODE_RING);
        run_phase(PHASE_ITEMS);

        // Drain: all results in, core idle, then room for a trailing flush sweep
        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        repeat (DEPTH + 8) @(posedge clk);

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: rx_byte_buffer_ring_linear_core.f
design/rbb_pkg.sv
design/rbb_ram.sv
design/rbb_ctrl.sv
design/rx_byte_buffer_ring_linear_core.sv
dv/rx_byte_buffer_ring_linear_core_tb.sv
